// File: rtl/core/ppc_pkg.sv
package ppc_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_VERTS_DEF  = 16;
   localparam int COORD_BITS_DEF = 32;

   // Vertex count field of a job; wide enough for the largest buffer (32).
   localparam int CNT_W = 6;

   localparam int OUT_W   = 32;
   localparam int PLANE_W = 32;
   localparam int FRAC    = 16;

   // Crossing parameter t is Q1.16 within [0,1].
   localparam int T_W     = 17;
   localparam int T_HALF  = 32768;
   localparam int DEN_LIM = 46;
   localparam int NUM_W   = DEN_LIM + T_W;

   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PLANE_A,
      CSR_PLANE_B,
      CSR_PLANE_C,
      CSR_PLANE_D
   } csr_idx_type;

   // One buffered polygon handed from the loader to the clipper.
   typedef struct packed {
      logic             bank;
      logic [CNT_W-1:0] count;
      logic             ovf;
   } job_type;

   // One result word before the last-word and overflow marks are added.
   typedef struct packed {
      logic [OUT_W-1:0] x;
      logic [OUT_W-1:0] y;
      logic [OUT_W-1:0] z;
      logic             on_plane;
      logic             empty_res;
   } res_type;

endpackage

// File: rtl/core/ppc_req_if.sv
interface ppc_req_if import ppc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] vx;
   logic [OUT_W-1:0] vy;
   logic [OUT_W-1:0] vz;
   logic             last_vertex;

   modport source (output valid, vx, vy, vz, last_vertex, input ready);
   modport sink   (input valid, vx, vy, vz, last_vertex, output ready);
endinterface

// File: rtl/core/ppc_rsp_if.sv
interface ppc_rsp_if import ppc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] ox;
   logic [OUT_W-1:0] oy;
   logic [OUT_W-1:0] oz;
   logic             on_plane;
   logic             is_last;
   logic             empty_res;
   logic             overflow;

   modport source (output valid, ox, oy, oz, on_plane, is_last, empty_res, overflow,
                   input ready);
   modport sink   (input valid, ox, oy, oz, on_plane, is_last, empty_res, overflow,
                   output ready);
endinterface

// File: rtl/core/ppc_ram.sv
module ppc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/ppc_front.sv
module ppc_front import ppc_pkg::*; #(
   parameter int MAX_VERTS  = MAX_VERTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int AW         = $clog2(2 * MAX_VERTS)
) (
   input  logic                    clock,
   input  logic                    reset,
   ppc_req_if.sink                 req,
   input  logic                    q_full,
   output logic                    job_push,
   output job_type                 job,
   output logic                    ram_we,
   output logic [AW-1:0]           ram_waddr,
   output logic [3*COORD_BITS-1:0] ram_wdata
);

   localparam int CW     = COORD_BITS;
   localparam int IDX_W  = $clog2(MAX_VERTS);
   localparam int CNT_LW = $clog2(MAX_VERTS + 1);

   logic [CNT_LW-1:0] count_ff;
   logic              ovf_ff;
   logic              bank_ff;
   logic              accept;
   logic              full;
   logic [CNT_LW-1:0] count_next;
   logic [CW-1:0]     cx, cy, cz;

   // Narrow coordinates are sign-extended from their own width later on.
   generate
      if (CW <= OUT_W) begin : g_narrow
         assign cx = req.vx[CW-1:0];
         assign cy = req.vy[CW-1:0];
         assign cz = req.vz[CW-1:0];
      end else begin : g_wide
         assign cx = {{(CW-OUT_W){1'b0}}, req.vx};
         assign cy = {{(CW-OUT_W){1'b0}}, req.vy};
         assign cz = {{(CW-OUT_W){1'b0}}, req.vz};
      end
   endgenerate

   assign req.ready  = !q_full;
   assign accept     = req.valid && req.ready;
   assign full       = (count_ff == CNT_LW'(MAX_VERTS));
   assign count_next = full ? count_ff : count_ff + CNT_LW'(1);

   assign ram_we    = accept && !full;
   assign ram_waddr = bank_ff ? AW'(MAX_VERTS) + AW'(count_ff[IDX_W-1:0])
                              : AW'(count_ff[IDX_W-1:0]);
   assign ram_wdata = {cz, cy, cx};

   assign job_push  = accept && req.last_vertex;
   assign job.bank  = bank_ff;
   assign job.count = CNT_W'(count_next);
   assign job.ovf   = ovf_ff || full;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         bank_ff  <= 1'b0;
      end else if (accept) begin
         if (req.last_vertex) begin
            count_ff <= '0;
            ovf_ff   <= 1'b0;
            bank_ff  <= !bank_ff;
         end else begin
            count_ff <= count_next;
            ovf_ff   <= ovf_ff || full;
         end
      end
   end

endmodule

// File: rtl/core/ppc_jobq.sv
module ppc_jobq import ppc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output job_type head
);

   // Two entries, one for each buffer bank.
   job_type    ent_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = ent_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

endmodule

// File: rtl/core/ppc_back.sv
module ppc_back import ppc_pkg::*; #(
   parameter int MAX_VERTS  = MAX_VERTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int AW         = $clog2(2 * MAX_VERTS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [PLANE_W-1:0]      plane_a,
   input  logic [PLANE_W-1:0]      plane_b,
   input  logic [PLANE_W-1:0]      plane_c,
   input  logic [PLANE_W-1:0]      plane_d,
   input  logic                    job_valid,
   input  job_type                 job,
   output logic                    job_pop,
   output logic [AW-1:0]           ram_raddr,
   input  logic [3*COORD_BITS-1:0] ram_rdata,
   ppc_rsp_if.source               rsp
);

   localparam int CW    = COORD_BITS;
   localparam int IDX_W = $clog2(MAX_VERTS);
   localparam int PW    = CW + 34;
   localparam int ACC_W = CW + 36;
   localparam int MAG_W = ACC_W - FRAC;
   localparam int HW    = (MAG_W + 1 > DEN_LIM + 1) ? MAG_W + 1 : DEN_LIM + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_LD, S_MUL, S_EVAL, S_HALVE, S_DIV, S_CRS,
      S_EMC, S_EMV, S_ADV, S_FIN
   } state_type;

   state_type               state_ff;
   logic [IDX_W-1:0]        i_ff;
   logic                    first_ff;
   logic [1:0]              k_ff;
   logic signed [CW-1:0]    cur_ff [3];
   logic signed [CW-1:0]    s_ff [3];
   logic [OUT_W-1:0]        r_ff [3];
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [PW-1:0]    prod_ff;
   logic                    cur_neg_ff, s_neg_ff;
   logic [MAG_W-1:0]        cur_mag_ff, s_mag_ff;
   logic [MAG_W-1:0]        ms_ff, md_ff;
   logic [NUM_W-1:0]        rem_ff, dsh_ff;
   logic [T_W-1:0]          t_ff;
   logic [4:0]              bit_ff;
   res_type                 pend_ff;
   logic                    pend_v_ff;
   res_type                 out_item_ff;
   logic                    out_v_ff, out_last_ff, out_ovf_ff;

   logic [IDX_W-1:0]        last_idx;
   logic signed [32:0]      mul_a;
   logic signed [CW:0]      mul_b;
   logic signed [CW:0]      diff;
   logic signed [CW-1:0]    s_sel;
   logic signed [PW-1:0]    r_next;
   logic                    d_neg;
   logic [ACC_W-1:0]        d_abs;
   logic [MAG_W-1:0]        d_mag;
   logic [HW-1:0]           den;
   logic                    den_big;
   logic [DEN_LIM-1:0]      dv;
   logic [NUM_W:0]          trial;
   logic                    out_free;
   logic                    out_load;
   res_type                 emit_item;
   res_type                 empty_item;

   function automatic logic [OUT_W-1:0] to_out(logic signed [CW-1:0] v);
      logic signed [PW-1:0] w;
      w = PW'(v);
      return w[OUT_W-1:0];
   endfunction

   assign last_idx  = IDX_W'(job.count - CNT_W'(1));
   assign ram_raddr = job.bank ? AW'(MAX_VERTS) + AW'(i_ff) : AW'(i_ff);

   // Shared multiplier: plane terms during the distance pass, t times the
   // edge delta during the crossing pass.
   always_comb begin
      case (k_ff)
         2'd0:    begin diff = (CW+1)'(cur_ff[0]) - (CW+1)'(s_ff[0]); s_sel = s_ff[0]; end
         2'd1:    begin diff = (CW+1)'(cur_ff[1]) - (CW+1)'(s_ff[1]); s_sel = s_ff[0]; end
         2'd2:    begin diff = (CW+1)'(cur_ff[2]) - (CW+1)'(s_ff[2]); s_sel = s_ff[1]; end
         default: begin diff = '0;                                      s_sel = s_ff[2]; end
      endcase
      if (state_ff == S_CRS) begin
         mul_a = $signed({16'b0, t_ff});
         mul_b = diff;
      end else begin
         case (k_ff)
            2'd0:    begin mul_a = 33'(signed'(plane_a)); mul_b = (CW+1)'(cur_ff[0]); end
            2'd1:    begin mul_a = 33'(signed'(plane_b)); mul_b = (CW+1)'(cur_ff[1]); end
            default: begin mul_a = 33'(signed'(plane_c)); mul_b = (CW+1)'(cur_ff[2]); end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= PW'(mul_a * mul_b);
   end

   // Crossing coordinate: s + t*(v - s) / 2^16, halves rounded upward.
   assign r_next = PW'(s_sel) + ((prod_ff + PW'(T_HALF)) >>> FRAC);

   // Whole-number magnitude of the Q16.16 distance, truncated toward zero.
   assign d_neg = acc_ff[ACC_W-1];
   assign d_abs = d_neg ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign d_mag = d_abs[ACC_W-1:FRAC];

   assign den     = HW'(ms_ff) + HW'(md_ff);
   assign den_big = (den >= (HW'(1) << DEN_LIM));
   assign dv      = den[DEN_LIM-1:0];
   assign trial   = {1'b0, rem_ff} - {1'b0, dsh_ff};

   assign out_free   = !out_v_ff || rsp.ready;
   // A new word enters the output register in this cycle.
   assign out_load   = (((state_ff == S_EMC) || (state_ff == S_EMV)) && pend_v_ff && out_free)
                       || ((state_ff == S_FIN) && out_free);
   assign empty_item = '{x: '0, y: '0, z: '0, on_plane: 1'b0, empty_res: 1'b1};
   always_comb begin
      if (state_ff == S_EMC) begin
         emit_item = '{x: r_ff[0], y: r_ff[1], z: r_ff[2], on_plane: 1'b1, empty_res: 1'b0};
      end else begin
         emit_item = '{x: to_out(cur_ff[0]), y: to_out(cur_ff[1]), z: to_out(cur_ff[2]),
                       on_plane: 1'b0, empty_res: 1'b0};
      end
   end

   assign job_pop = (state_ff == S_FIN) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         if (out_v_ff && rsp.ready && !out_load) begin
            out_v_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (job_valid) begin
                  i_ff     <= last_idx;
                  first_ff <= 1'b1;
                  state_ff <= S_RD;
               end
            end
            S_RD: begin
               state_ff <= S_LD;
            end
            S_LD: begin
               cur_ff[0] <= ram_rdata[CW-1:0];
               cur_ff[1] <= ram_rdata[2*CW-1:CW];
               cur_ff[2] <= ram_rdata[3*CW-1:2*CW];
               acc_ff    <= ACC_W'(signed'(plane_d)) <<< FRAC;
               k_ff      <= 2'd0;
               state_ff  <= S_MUL;
            end
            S_MUL: begin
               if (k_ff != 2'd0) begin
                  acc_ff <= acc_ff + ACC_W'(prod_ff);
               end
               if (k_ff == 2'd3) begin
                  state_ff <= S_EVAL;
               end else begin
                  k_ff <= k_ff + 2'd1;
               end
            end
            S_EVAL: begin
               cur_neg_ff <= d_neg;
               cur_mag_ff <= d_mag;
               if (first_ff) begin
                  s_ff     <= cur_ff;
                  s_neg_ff <= d_neg;
                  s_mag_ff <= d_mag;
                  first_ff <= 1'b0;
                  i_ff     <= '0;
                  state_ff <= S_RD;
               end else if (d_neg != s_neg_ff) begin
                  ms_ff    <= s_mag_ff;
                  md_ff    <= d_mag;
                  state_ff <= S_HALVE;
               end else if (d_neg) begin
                  state_ff <= S_EMV;
               end else begin
                  state_ff <= S_ADV;
               end
            end
            S_HALVE: begin
               k_ff <= 2'd0;
               if (den_big) begin
                  ms_ff <= ms_ff >> 1;
                  md_ff <= md_ff >> 1;
               end else if (den == '0) begin
                  t_ff     <= T_W'(T_HALF);
                  state_ff <= S_CRS;
               end else begin
                  rem_ff   <= (NUM_W'(ms_ff) << FRAC) + NUM_W'(dv >> 1);
                  dsh_ff   <= NUM_W'(dv) << FRAC;
                  t_ff     <= '0;
                  bit_ff   <= 5'd16;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (!trial[NUM_W]) begin
                  rem_ff <= trial[NUM_W-1:0];
               end
               t_ff   <= {t_ff[T_W-2:0], !trial[NUM_W]};
               dsh_ff <= dsh_ff >> 1;
               bit_ff <= bit_ff - 5'd1;
               if (bit_ff == 5'd0) begin
                  state_ff <= S_CRS;
               end
            end
            S_CRS: begin
               case (k_ff)
                  2'd1:    r_ff[0] <= r_next[OUT_W-1:0];
                  2'd2:    r_ff[1] <= r_next[OUT_W-1:0];
                  2'd3:    r_ff[2] <= r_next[OUT_W-1:0];
                  default: ;
               endcase
               if (k_ff == 2'd3) begin
                  state_ff <= S_EMC;
               end else begin
                  k_ff <= k_ff + 2'd1;
               end
            end
            S_EMC, S_EMV: begin
               // One word is held back so the final one can carry is_last.
               if (!pend_v_ff || out_free) begin
                  if (pend_v_ff) begin
                     out_item_ff <= pend_ff;
                     out_last_ff <= 1'b0;
                     out_ovf_ff  <= job.ovf;
                     out_v_ff    <= 1'b1;
                  end
                  pend_ff   <= emit_item;
                  pend_v_ff <= 1'b1;
                  state_ff  <= (state_ff == S_EMC && cur_neg_ff) ? S_EMV : S_ADV;
               end
            end
            S_ADV: begin
               s_ff     <= cur_ff;
               s_neg_ff <= cur_neg_ff;
               s_mag_ff <= cur_mag_ff;
               if (i_ff == last_idx) begin
                  state_ff <= S_FIN;
               end else begin
                  i_ff     <= i_ff + IDX_W'(1);
                  state_ff <= S_RD;
               end
            end
            S_FIN: begin
               if (out_free) begin
                  out_item_ff <= pend_v_ff ? pend_ff : empty_item;
                  out_last_ff <= 1'b1;
                  out_ovf_ff  <= job.ovf;
                  out_v_ff    <= 1'b1;
                  pend_v_ff   <= 1'b0;
                  state_ff    <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.valid     = out_v_ff;
   assign rsp.ox        = out_item_ff.x;
   assign rsp.oy        = out_item_ff.y;
   assign rsp.oz        = out_item_ff.z;
   assign rsp.on_plane  = out_item_ff.on_plane;
   assign rsp.empty_res = out_item_ff.empty_res;
   assign rsp.is_last   = out_last_ff;
   assign rsp.overflow  = out_ovf_ff;

endmodule

// File: rtl/core/polygon_plane_clip_top.sv
// Channel   Dir  Handshake          Word
// req_chan  in   valid/ready        vx, vy, vz, last_vertex
// rsp_chan  out  valid/ready        ox, oy, oz, on_plane, is_last, empty_res, overflow
// csr_*     in   csr_we, no ready   csr_idx selects plane_a..plane_d, csr_wdata
//
// Loading takes one vertex word per cycle while the job queue has room. The
// clip walk then visits each vertex with a buffer read, three shared-multiplier
// passes for the plane distance and a classify step; an edge that crosses the
// plane adds the halving steps, the 17-step restoring divider for t and
// three multiplier passes for the crossing point.
// Reset is synchronous and clears control state and the plane coefficients
// only; the vertex buffer needs no clearing pass. A stalled result channel holds
// the clipper, and with two buffer banks the loader can take a whole new polygon meanwhile.
module polygon_plane_clip_top import ppc_pkg::*; #(
   parameter int MAX_VERTS  = MAX_VERTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   ppc_req_if.sink              req_chan,
   ppc_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_idx,
   input  logic [PLANE_W-1:0]   csr_wdata
);

   localparam int AW = $clog2(2 * MAX_VERTS);

   // Plane coefficients, to be written only while the block is idle; the block itself does not enforce this.
   logic [PLANE_W-1:0] plane_a_ff, plane_b_ff, plane_c_ff, plane_d_ff;

   logic                    job_push, job_pop, q_full, q_not_empty;
   job_type                 push_job, head_job;
   logic                    ram_we;
   logic [AW-1:0]           ram_waddr, ram_raddr;
   logic [3*COORD_BITS-1:0] ram_wdata, ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_a_ff <= '0;
         plane_b_ff <= '0;
         plane_c_ff <= '0;
         plane_d_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_idx))
            CSR_PLANE_A: plane_a_ff <= csr_wdata;
            CSR_PLANE_B: plane_b_ff <= csr_wdata;
            CSR_PLANE_C: plane_c_ff <= csr_wdata;
            CSR_PLANE_D: plane_d_ff <= csr_wdata;
         endcase
      end
   end

   // The loader fills one bank while the clipper walks the other.
   ppc_front #(.MAX_VERTS(MAX_VERTS), .COORD_BITS(COORD_BITS), .AW(AW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .q_full    (q_full),
      .job_push  (job_push),
      .job       (push_job),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata)
   );

   ppc_ram #(.WIDTH(3 * COORD_BITS), .DEPTH(2 * MAX_VERTS), .AW(AW)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // A job stays in the queue until its last word is loaded into the output
   // register, so the queue depth also tracks which banks are busy.
   ppc_jobq u_jobq (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (push_job),
      .pop       (job_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head_job)
   );

   ppc_back #(.MAX_VERTS(MAX_VERTS), .COORD_BITS(COORD_BITS), .AW(AW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .plane_a   (plane_a_ff),
      .plane_b   (plane_b_ff),
      .plane_c   (plane_c_ff),
      .plane_d   (plane_d_ff),
      .job_valid (q_not_empty),
      .job       (head_job),
      .job_pop   (job_pop),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .rsp       (rsp_chan)
   );

endmodule

// File: rtl/core/ppc_check.sv
module ppc_check import ppc_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [OUT_W-1:0] ox,
   input logic [OUT_W-1:0] oy,
   input logic [OUT_W-1:0] oz,
   input logic             on_plane,
   input logic             is_last,
   input logic             empty_res,
   input logic             overflow
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({ox, oy, oz, on_plane, is_last,
                                                         empty_res, overflow}))
      else $error("result word changed while stalled");

   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && empty_res |-> is_last && !on_plane && ox == '0 && oy == '0 && oz == '0)
      else $error("empty result word is malformed");

   a_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word shown right after reset");

   a_empty_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !is_last |=> !(rsp_valid && empty_res))
      else $error("empty word follows a word of the same polygon");

endmodule

bind polygon_plane_clip_top ppc_check u_ppc_check (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .ox        (rsp_chan.ox),
   .oy        (rsp_chan.oy),
   .oz        (rsp_chan.oz),
   .on_plane  (rsp_chan.on_plane),
   .is_last   (rsp_chan.is_last),
   .empty_res (rsp_chan.empty_res),
   .overflow  (rsp_chan.overflow)
);
